FILE: rtl/jlgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlgr_pkg
// Shared types and constants of the Jacobi grid relaxer: request codes,
// configuration register indexes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package jlgr_pkg;

  localparam int REQ_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CELL_W      = 32;
  localparam int TIME_W      = 48;
  localparam int STEP_W      = 32;
  localparam int SIZE_W      = 7;
  localparam int ADDR_FLD_W  = 6;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 88;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_SWEEP = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd2;

  localparam logic [SIZE_W-1:0] COLS_RST = 7'd10;
  localparam logic [SIZE_W-1:0] ROWS_RST = 7'd20;
  localparam logic [STEP_W-1:0] STEP_RST = 32'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_ACCESS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic cnt_clr;
    logic cnt_adv;
    logic init_wr;
    logic sweep_rd;
    logic cell_wr;
    logic cell_rd;
    logic time_clr;
    logic time_add;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    req_t req;
    logic col_last;
    logic row_last;
    logic pipe_busy;
  } dp_stat_t;

endpackage

FILE: rtl/jlgr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlgr_ctrl
// Request sequencer: takes one transaction at a time, steps the datapath
// through initialize, sweep or cell access, and owns the result valid flag.
// ----------------------------------------------------------------------------
module jlgr_ctrl import jlgr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (stat.req)
          REQ_INIT: begin
            cmd.time_clr = 1'b1;
            state_next   = ST_INIT;
          end
          REQ_SWEEP: begin
            cmd.time_add = 1'b1;
            state_next   = ST_SWEEP;
          end
          default: begin
            state_next = ST_ACCESS;
          end
        endcase
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        cmd.cnt_adv = 1'b1;
        if (stat.col_last && stat.row_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        cmd.cnt_adv  = 1'b1;
        if (stat.col_last && stat.row_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // hold until the last stencil write has landed
        if (!stat.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_ACCESS: begin
        cmd.cell_wr = (stat.req == REQ_WRITE);
        cmd.cell_rd = (stat.req == REQ_READ);
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/jlgr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlgr_datapath
// Grid memory, line buffer, stencil pipeline, scan counters, model time,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module jlgr_datapath import jlgr_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [REQ_W-1:0]      in_req,
  input  logic [ADDR_FLD_W-1:0] in_row,
  input  logic [ADDR_FLD_W-1:0] in_col,
  input  logic [CELL_W-1:0]     in_cell,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat,
  output logic [CELL_W-1:0]     cell_out,
  output logic [TIME_W-1:0]     time_now,
  output logic                  status
);

  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  logic [SIZE_W-1:0] grid_cols, grid_rows;
  logic [STEP_W-1:0] time_step;
  logic [CW-1:0]     cols_u;
  logic [RW-1:0]     rows_u;

  req_t              req;
  logic              in_grid;
  logic [AW-1:0]     cell_addr;
  logic [CELL_W-1:0] cell_q;

  logic [RIW-1:0]    r_cnt;
  logic [CIW-1:0]    c_cnt;
  logic              col_last, row_last;

  logic [CELL_W-1:0] grid_mem [DEPTH];
  logic [CELL_W-1:0] upper_buf [MAX_COLS];
  logic [CELL_W-1:0] rd_a, rd_b, up_q;
  logic [AW-1:0]     addr_a, addr_b, addr_cur;
  logic              g_we;
  logic [AW-1:0]     g_waddr;
  logic [CELL_W-1:0] g_wdata;

  logic              rd_vld;
  logic [RIW-1:0]    rd_row;
  logic [CIW-1:0]    rd_col;
  logic [CELL_W-1:0] win_w, win_c, up_d, bl_d;
  logic [CELL_W+1:0] sum;
  logic              wr_vld;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;

  logic [CW-1:0]     rem_c;
  logic [CW+CIW-1:0] prod;
  logic [47:0]       prod_sh;
  logic [CELL_W-1:0] init_val;

  logic [TIME_W-1:0] model_time;
  logic [TIME_W:0]   time_sum;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= COLS_RST;
      grid_rows <= ROWS_RST;
      time_step <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: grid_cols <= cfg_data[SIZE_W-1:0];
        CFG_ROWS: grid_rows <= cfg_data[SIZE_W-1:0];
        CFG_STEP: time_step <= cfg_data[STEP_W-1:0];
        default:  ;
      endcase
    end
  end

  // clamp sizes into the supported range
  always_comb begin
    if (int'(grid_cols) > MAX_COLS) begin
      cols_u = CW'(MAX_COLS);
    end else if (grid_cols < 7'd2) begin
      cols_u = CW'(2);
    end else begin
      cols_u = CW'(grid_cols);
    end
    if (int'(grid_rows) > MAX_ROWS) begin
      rows_u = RW'(MAX_ROWS);
    end else if (grid_rows < 7'd2) begin
      rows_u = RW'(2);
    end else begin
      rows_u = RW'(grid_rows);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req       <= req_t'(in_req);
      in_grid   <= (int'(in_row) < int'(rows_u)) && (int'(in_col) < int'(cols_u));
      cell_addr <= AW'(int'(in_row) * MAX_COLS + int'(in_col));
      cell_q    <= in_cell;
    end
  end

  // scan counters: whole memory for initialize, used rows 0..rows-2 for a sweep
  always_comb begin
    if (req == REQ_INIT) begin
      col_last = (c_cnt == CIW'(MAX_COLS - 1));
      row_last = (r_cnt == RIW'(MAX_ROWS - 1));
    end else begin
      col_last = (c_cnt == CIW'(cols_u - CW'(1)));
      row_last = (r_cnt == RIW'(rows_u - RW'(2)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      r_cnt <= '0;
      c_cnt <= '0;
    end else if (cmd.cnt_adv) begin
      if (col_last) begin
        c_cnt <= '0;
        r_cnt <= r_cnt + RIW'(1);
      end else begin
        c_cnt <= c_cnt + CIW'(1);
      end
    end
  end

  // initial boundary profile i*(cols-1-i) on the last used row
  always_comb begin
    rem_c   = cols_u - CW'(1) - CW'(c_cnt);
    prod    = (CW+CIW)'(c_cnt) * (CW+CIW)'(rem_c);
    prod_sh = 48'(prod) << 16;
    if ((r_cnt == RIW'(rows_u - RW'(1))) && (int'(c_cnt) < int'(cols_u))) begin
      init_val = prod_sh[CELL_W-1:0];
    end else begin
      init_val = '0;
    end
  end

  // grid memory ports
  always_comb begin
    addr_cur = AW'(int'(r_cnt) * MAX_COLS + int'(c_cnt));
    addr_b   = AW'((int'(r_cnt) + 1) * MAX_COLS + int'(c_cnt));
    addr_a   = cmd.cell_rd ? cell_addr : addr_cur;
    g_we     = 1'b0;
    g_waddr  = addr_cur;
    g_wdata  = init_val;
    if (wr_vld) begin
      g_we    = 1'b1;
      g_waddr = wr_addr;
      g_wdata = wr_data;
    end else if (cmd.init_wr) begin
      g_we = 1'b1;
    end else if (cmd.cell_wr && in_grid) begin
      g_we    = 1'b1;
      g_waddr = cell_addr;
      g_wdata = cell_q;
    end
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    if (cmd.sweep_rd || cmd.cell_rd) begin
      rd_a <= grid_mem[addr_a];
    end
    if (cmd.sweep_rd) begin
      rd_b <= grid_mem[addr_b];
    end
  end

  // line buffer of the old row above the one being relaxed
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      upper_buf[rd_col] <= rd_a;
    end
    if (cmd.sweep_rd) begin
      up_q <= upper_buf[c_cnt];
    end
  end

  // stencil pipeline: issue, arrive, write back
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      wr_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.sweep_rd;
      wr_vld <= rd_vld && (rd_col >= CIW'(2)) && (rd_row != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_rd) begin
      rd_row <= r_cnt;
      rd_col <= c_cnt;
    end
    if (rd_vld) begin
      win_w   <= win_c;
      win_c   <= rd_a;
      up_d    <= up_q;
      bl_d    <= rd_b;
      wr_addr <= AW'(int'(rd_row) * MAX_COLS + int'(rd_col) - 1);
      wr_data <= sum[CELL_W+1:2];
    end
  end

  // north + south + west + east, floor divided by four
  assign sum = {{2{up_d[CELL_W-1]}}, up_d} + {{2{bl_d[CELL_W-1]}}, bl_d}
             + {{2{win_w[CELL_W-1]}}, win_w} + {{2{rd_a[CELL_W-1]}}, rd_a};

  // model time, saturating
  assign time_sum = {1'b0, model_time} + (TIME_W+1)'(time_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      model_time <= '0;
    end else if (cmd.time_clr) begin
      model_time <= '0;
    end else if (cmd.time_add) begin
      model_time <= time_sum[TIME_W] ? {TIME_W{1'b1}} : time_sum[TIME_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_out <= ((req == REQ_READ) && in_grid) ? rd_a : '0;
      time_now <= model_time;
      status   <= ((req == REQ_READ) || (req == REQ_WRITE)) && !in_grid;
    end
  end

  assign stat.req       = req;
  assign stat.col_last  = col_last;
  assign stat.row_last  = row_last;
  assign stat.pipe_busy = rd_vld || wr_vld;

endmodule

FILE: rtl/jacobi_laplace_grid_relaxer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_laplace_grid_relaxer
// Grid of signed Q16.16 cells relaxed by 5-point Jacobi sweeps, with cell
// access, initialization and a saturating model time.
//
//   channel  direction  handshake              payload
//   s_axis   in         s_axis_tvalid/tready   tuser: req_type; tdata: row,col,cell_in
//   m_axis   out        m_axis_tvalid/tready   tdata: cell_out,time_now,status
//   cfg      in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Cell read or write: dispatch, one memory access, then the result.
// Initialize: one grid word written per cycle over the whole memory.
// Sweep: one column per cycle through the two grid read ports; row 0 is a
// copy pass into the line buffer.
// Items are handled one at a time; a new transaction is taken while the
// previous result waits in the output register. Reset loads the default
// sizes and time step and clears the time; grid contents stay undefined until
// the first initialize request.
// ----------------------------------------------------------------------------
module jacobi_laplace_grid_relaxer import jlgr_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [REQ_W-1:0]       s_axis_tuser,   // req_type[1:0]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // row[5:0], col[11:6], cell_in[43:12]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // cell_out[31:0], time_now[79:32],
                                                 // status[80]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]            cfg_data
);

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [CELL_W-1:0] cell_out;
  logic [TIME_W-1:0] time_now;
  logic              status;

  assign cfg_ready = 1'b1;

  jlgr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  jlgr_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (s_axis_tuser),
    .in_row    (s_axis_tdata[5:0]),
    .in_col    (s_axis_tdata[11:6]),
    .in_cell   (s_axis_tdata[43:12]),
    .cmd       (cmd),
    .stat      (stat),
    .cell_out  (cell_out),
    .time_now  (time_now),
    .status    (status)
  );

  assign m_axis_tdata = {7'd0, status, time_now, cell_out};

endmodule

FILE: rtl/jlgr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlgr_checker
// Port-level checks of the grid relaxer, bound to the top level.
// ----------------------------------------------------------------------------
module jlgr_checker import jlgr_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight: no transaction on the next cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a request is in progress");

  // a new result only appears while a request is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared with no request in progress");

  // an out-of-range access never returns cell data
  a_status_zero_cell: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[80] |-> m_axis_tdata[31:0] == 32'd0)
    else $error("cell data returned with error status");

endmodule

bind jacobi_laplace_grid_relaxer jlgr_checker u_jlgr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
